FILE: design/rpa_pkg.sv
// Shared types, codes and helpers of the resource pool allocator.
// No dependencies; imported by rpa_ram users and the top level.
package rpa_pkg;

   localparam int NPOOLS    = 3;
   localparam int GRANT_CAP = 24;

   // request kinds, carried on req_tuser
   localparam logic [2:0] MODE_RESERVE     = 3'd0;
   localparam logic [2:0] MODE_RELEASE     = 3'd1;
   localparam logic [2:0] MODE_RELEASE_ALL = 3'd2;
   localparam logic [2:0] MODE_DISCONNECT  = 3'd3;
   localparam logic [2:0] MODE_CANCEL      = 3'd4;

   // status codes
   localparam logic [2:0] ST_GRANTED    = 3'd0;
   localparam logic [2:0] ST_QUEUED     = 3'd1;
   localparam logic [2:0] ST_DONE       = 3'd2;
   localparam logic [2:0] ST_BAD        = 3'd3;
   localparam logic [2:0] ST_NO_JOB     = 3'd4;
   localparam logic [2:0] ST_OVER       = 3'd5;
   localparam logic [2:0] ST_TABLE_FULL = 3'd6;
   localparam logic [2:0] ST_QUEUE_FULL = 3'd7;

   // configuration register indexes
   localparam logic [1:0] REG_TOTAL_CPU  = 2'd0;
   localparam logic [1:0] REG_TOTAL_GPU  = 2'd1;
   localparam logic [1:0] REG_TOTAL_MEM  = 2'd2;
   localparam logic [1:0] REG_MAX_GRANTS = 2'd3;

   localparam logic [1:0] RES_NONE = 2'd3;
   localparam logic [1:0] POOL_END = 2'd3;

   typedef logic [15:0] amt_type;
   typedef logic [NPOOLS-1:0][15:0] pool_vec_type;

   typedef struct packed {
      logic [7:0]  client;
      logic [15:0] job;
   } key_type;

   typedef struct packed {
      logic [7:0]  client;
      logic [15:0] job;
      logic [15:0] amount;
   } pend_type;

   function automatic amt_type sat_add(amt_type a, amt_type b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

endpackage

FILE: design/rpa_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Standalone; used for the key, holding and queue stores.
module rpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: design/resource_pool_allocator.sv
// A bad, queued or queue-full request goes from decode straight to its status result.
// Reserve scans the key table, a read and a compare state per entry; a release adds the holding
// update and the pool walk; each grant adds a table scan and moves up the queued entries behind
// it. Disconnect scans the table, visits the queued entries of each pool, shifts out the
// client's, then walks the grants. A stalled result holds the sequencer.
// Throughput: one request at a time, taken again once the status result is registered.
// Reset (synchronous): totals and available units zero, max_grants 24, table and queues empty.
// Depends on rpa_pkg and rpa_ram.
module resource_pool_allocator #(
   parameter int ACTIVE_JOBS = 16,
   parameter int QUEUE_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // client[7:0] job_id[23:8] resource[25:24] amount[41:26]
   input  logic [2:0]  req_tuser,   // mode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // status[2:0] grant_client[10:3] grant_job[26:11]
                                    // grant_resource[28:27] grant_amount[44:29]
                                    // grant_number[49:45]
   output logic [0:0]  rsp_tuser,   // kind[0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import rpa_pkg::*;

   localparam int AW  = $clog2(ACTIVE_JOBS);
   localparam int QW  = $clog2(QUEUE_DEPTH);
   localparam int CW  = QW + 1;
   localparam int QAW = QW + 2;
   localparam int QDEPTH_MEM = NPOOLS << QW;

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_FIND_RD, S_FIND_CMP, S_HELD_RD, S_HELD_UPD,
      S_DISC_RD, S_DISC_CMP, S_PURGE_RD, S_PURGE_CMP, S_CAN_RD, S_CAN_CMP,
      S_SH_RD, S_SH_WR, S_GHEAD, S_GCHECK, S_GEMIT, S_STATUS
   } state_type;

   typedef enum logic [1:0] {P_RESERVE, P_RELEASE, P_GRANT} purpose_type;

   state_type   state_ff, ret_ff;
   purpose_type purpose_ff;

   logic [2:0]  mode_ff;
   logic [7:0]  client_ff;
   logic [15:0] job_ff;
   logic [1:0]  res_ff;
   logic [15:0] amount_ff;
   logic [2:0]  status_ff;

   pool_vec_type total_ff, avail_ff;
   logic [4:0]   maxg_ff;
   logic [NPOOLS-1:0][CW-1:0] qcnt_ff;
   logic [ACTIVE_JOBS-1:0]    valid_ff;

   logic [AW-1:0] scan_ff, entry_ff, free_idx_ff;
   logic          free_found_ff, new_ff;
   logic [1:0]    pool_ff;
   logic [CW-1:0] qk_ff, qpos_ff;
   logic [4:0]    ngrant_ff;

   logic        rsp_valid_ff, rsp_kind_ff, rsp_last_ff;
   logic [55:0] rsp_data_ff;

   // memory ports
   logic               key_we, held_we, q_we;
   logic [AW-1:0]      key_waddr, held_waddr, held_raddr;
   logic [QAW-1:0]     q_waddr, q_raddr;
   key_type            key_wdata, key_rd;
   pool_vec_type       held_wdata, held_rd;
   pend_type           q_wdata, q_rd;

   rpa_ram #(.WIDTH(24), .DEPTH(ACTIVE_JOBS)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(key_waddr), .wr_data(key_wdata),
      .rd_addr(scan_ff), .rd_data(key_rd)
   );

   rpa_ram #(.WIDTH(48), .DEPTH(ACTIVE_JOBS)) u_held_ram (
      .clock(clock), .wr_en(held_we), .wr_addr(held_waddr), .wr_data(held_wdata),
      .rd_addr(held_raddr), .rd_data(held_rd)
   );

   rpa_ram #(.WIDTH(40), .DEPTH(QDEPTH_MEM)) u_queue_ram (
      .clock(clock), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
      .rd_addr(q_raddr), .rd_data(q_rd)
   );

   // request decode helpers
   logic          res_bad, over_total, avail_ok, queue_full, enqueue;
   logic [CW-1:0] res_cnt, pool_cnt, qnext;
   logic [4:0]    grant_limit;
   logic          key_hit, free_now, scan_last;
   logic [AW-1:0] free_sel;

   always_comb begin
      res_bad     = (res_ff == RES_NONE);
      over_total  = !res_bad && (amount_ff > total_ff[res_ff]);
      avail_ok    = !res_bad && (avail_ff[res_ff] >= amount_ff);
      res_cnt     = res_bad ? '0 : qcnt_ff[res_ff];
      queue_full  = (res_cnt >= CW'(QUEUE_DEPTH));
      enqueue     = (state_ff == S_DECODE) && (mode_ff == MODE_RESERVE) && !res_bad &&
                    !over_total && !avail_ok && !queue_full;
      pool_cnt    = (pool_ff == POOL_END) ? '0 : qcnt_ff[pool_ff];
      qnext       = qpos_ff + CW'(1);
      grant_limit = (maxg_ff > 5'(GRANT_CAP)) ? 5'(GRANT_CAP) : maxg_ff;
      key_hit     = valid_ff[scan_ff] && (key_rd.client == client_ff) &&
                    (key_rd.job == job_ff);
      free_now    = free_found_ff || !valid_ff[scan_ff];
      free_sel    = free_found_ff ? free_idx_ff : scan_ff;
      scan_last   = (scan_ff == AW'(ACTIVE_JOBS - 1));
   end

   // holding update for reserve, grant and release; pool refund for disconnect
   pool_vec_type held_cur, held_mod, avail_mod, avail_disc;
   logic         over_rel, drop_entry;

   always_comb begin
      held_cur  = new_ff ? '0 : held_rd;
      held_mod  = held_cur;
      avail_mod = avail_ff;
      over_rel  = 1'b0;
      if (purpose_ff == P_RELEASE) begin
         if (mode_ff == MODE_RELEASE_ALL) begin
            for (int p = 0; p < NPOOLS; p++) begin
               avail_mod[p] = sat_add(avail_ff[p], held_cur[p]);
            end
            held_mod = '0;
         end else if (!res_bad) begin
            over_rel          = held_cur[res_ff] < amount_ff;
            held_mod[res_ff]  = held_cur[res_ff] - amount_ff;
            avail_mod[res_ff] = sat_add(avail_ff[res_ff], amount_ff);
         end
      end else if (!res_bad) begin
         held_mod[res_ff]  = sat_add(held_cur[res_ff], amount_ff);
         avail_mod[res_ff] = avail_ff[res_ff] - amount_ff;
      end
      drop_entry = (held_mod == '0);
      for (int p = 0; p < NPOOLS; p++) begin
         avail_disc[p] = sat_add(avail_ff[p], held_rd[p]);
      end
   end

   // drive memory ports from the sequencer state
   always_comb begin
      key_we     = (state_ff == S_HELD_UPD) && new_ff;
      key_waddr  = entry_ff;
      key_wdata  = '{client: client_ff, job: job_ff};
      held_we    = (state_ff == S_HELD_UPD) && !over_rel;
      held_waddr = entry_ff;
      held_wdata = held_mod;
      held_raddr = (state_ff == S_HELD_RD) ? entry_ff : scan_ff;
      q_we       = enqueue || (state_ff == S_SH_WR);
      if (state_ff == S_SH_WR) begin
         q_waddr = {pool_ff, qpos_ff[QW-1:0]};
         q_wdata = q_rd;
      end else begin
         q_waddr = {res_ff, res_cnt[QW-1:0]};
         q_wdata = '{client: client_ff, job: job_ff, amount: amount_ff};
      end
      case (state_ff)
         S_SH_RD:  q_raddr = {pool_ff, qnext[QW-1:0]};
         S_GHEAD:  q_raddr = {pool_ff, {QW{1'b0}}};
         default:  q_raddr = {pool_ff, qk_ff[QW-1:0]};
      endcase
   end

   logic out_free, rsp_load;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_load = out_free && (state_ff == S_GEMIT || state_ff == S_STATUS);

   // sequencer, pool state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ret_ff        <= S_IDLE;
         purpose_ff    <= P_RESERVE;
         total_ff      <= '0;
         avail_ff      <= '0;
         maxg_ff       <= 5'(GRANT_CAP);
         qcnt_ff       <= '0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         ngrant_ff     <= '0;
         free_found_ff <= 1'b0;
         new_ff        <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end

         // configuration transfer
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TOTAL_CPU, REG_TOTAL_GPU, REG_TOTAL_MEM: begin
                  total_ff[csr_index] <= csr_data;
                  avail_ff[csr_index] <= csr_data;
               end
               REG_MAX_GRANTS: maxg_ff <= csr_data[4:0];
               default: ;
            endcase
         end

         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  mode_ff   <= req_tuser;
                  client_ff <= req_tdata[7:0];
                  job_ff    <= req_tdata[23:8];
                  res_ff    <= req_tdata[25:24];
                  amount_ff <= req_tdata[41:26];
                  ngrant_ff <= '0;
                  state_ff  <= S_DECODE;
               end
            end

            S_DECODE: begin
               scan_ff       <= '0;
               free_found_ff <= 1'b0;
               new_ff        <= 1'b0;
               qk_ff         <= '0;
               pool_ff       <= res_ff;
               status_ff     <= ST_BAD;
               state_ff      <= S_STATUS;
               case (mode_ff)
                  MODE_RESERVE: begin
                     if (!res_bad && !over_total) begin
                        if (avail_ok) begin
                           purpose_ff <= P_RESERVE;
                           state_ff   <= S_FIND_RD;
                        end else if (queue_full) begin
                           status_ff <= ST_QUEUE_FULL;
                        end else begin
                           qcnt_ff[res_ff] <= res_cnt + CW'(1);
                           status_ff       <= ST_QUEUED;
                        end
                     end
                  end
                  MODE_RELEASE, MODE_RELEASE_ALL: begin
                     if (!(mode_ff == MODE_RELEASE && (amount_ff == '0 || res_bad))) begin
                        purpose_ff <= P_RELEASE;
                        state_ff   <= S_FIND_RD;
                     end
                  end
                  MODE_DISCONNECT: state_ff <= S_DISC_RD;
                  MODE_CANCEL: begin
                     if (!res_bad) begin
                        state_ff <= S_CAN_RD;
                     end
                  end
                  default: ;
               endcase
            end

            // key table scan, a read and a compare state per entry
            S_FIND_RD: state_ff <= S_FIND_CMP;

            S_FIND_CMP: begin
               if (!free_found_ff && !valid_ff[scan_ff]) begin
                  free_found_ff <= 1'b1;
                  free_idx_ff   <= scan_ff;
               end
               if (key_hit) begin
                  entry_ff <= scan_ff;
                  new_ff   <= 1'b0;
                  state_ff <= S_HELD_RD;
               end else if (scan_last) begin
                  if (purpose_ff == P_RELEASE) begin
                     status_ff <= ST_NO_JOB;
                     state_ff  <= S_STATUS;
                  end else if (free_now) begin
                     entry_ff <= free_sel;
                     new_ff   <= 1'b1;
                     state_ff <= S_HELD_RD;
                  end else if (purpose_ff == P_RESERVE) begin
                     status_ff <= ST_TABLE_FULL;
                     state_ff  <= S_STATUS;
                  end else begin
                     pool_ff  <= pool_ff + 2'd1;
                     state_ff <= S_GHEAD;
                  end
               end else begin
                  scan_ff  <= scan_ff + AW'(1);
                  state_ff <= S_FIND_RD;
               end
            end

            S_HELD_RD: state_ff <= S_HELD_UPD;

            S_HELD_UPD: begin
               case (purpose_ff)
                  P_RESERVE: begin
                     avail_ff <= avail_mod;
                     if (new_ff) begin
                        valid_ff[entry_ff] <= 1'b1;
                     end
                     status_ff <= ST_GRANTED;
                     state_ff  <= S_STATUS;
                  end
                  P_GRANT: begin
                     avail_ff <= avail_mod;
                     if (new_ff) begin
                        valid_ff[entry_ff] <= 1'b1;
                     end
                     state_ff <= S_GEMIT;
                  end
                  default: begin
                     if (over_rel) begin
                        status_ff <= ST_OVER;
                        state_ff  <= S_STATUS;
                     end else begin
                        avail_ff <= avail_mod;
                        if (drop_entry) begin
                           valid_ff[entry_ff] <= 1'b0;
                        end
                        pool_ff  <= '0;
                        state_ff <= S_GHEAD;
                     end
                  end
               endcase
            end

            // disconnect: free every entry of the client
            S_DISC_RD: state_ff <= S_DISC_CMP;

            S_DISC_CMP: begin
               if (valid_ff[scan_ff] && key_rd.client == client_ff) begin
                  avail_ff          <= avail_disc;
                  valid_ff[scan_ff] <= 1'b0;
               end
               if (scan_last) begin
                  pool_ff  <= '0;
                  qk_ff    <= '0;
                  state_ff <= S_PURGE_RD;
               end else begin
                  scan_ff  <= scan_ff + AW'(1);
                  state_ff <= S_DISC_RD;
               end
            end

            // drop the client's queued requests
            S_PURGE_RD: begin
               if (pool_ff == POOL_END) begin
                  pool_ff  <= '0;
                  state_ff <= S_GHEAD;
               end else if (qk_ff >= pool_cnt) begin
                  pool_ff <= pool_ff + 2'd1;
                  qk_ff   <= '0;
               end else begin
                  state_ff <= S_PURGE_CMP;
               end
            end

            S_PURGE_CMP: begin
               if (q_rd.client == client_ff) begin
                  qpos_ff  <= qk_ff;
                  ret_ff   <= S_PURGE_RD;
                  state_ff <= S_SH_RD;
               end else begin
                  qk_ff    <= qk_ff + CW'(1);
                  state_ff <= S_PURGE_RD;
               end
            end

            // cancel: remove first queued request of the job
            S_CAN_RD: begin
               if (qk_ff >= pool_cnt) begin
                  status_ff <= ST_NO_JOB;
                  state_ff  <= S_STATUS;
               end else begin
                  state_ff <= S_CAN_CMP;
               end
            end

            S_CAN_CMP: begin
               if (q_rd.job == job_ff) begin
                  qpos_ff   <= qk_ff;
                  ret_ff    <= S_STATUS;
                  status_ff <= ST_DONE;
                  state_ff  <= S_SH_RD;
               end else begin
                  qk_ff    <= qk_ff + CW'(1);
                  state_ff <= S_CAN_RD;
               end
            end

            // close the gap at qpos, a read and a write state per entry
            S_SH_RD: begin
               if (qnext >= pool_cnt) begin
                  qcnt_ff[pool_ff] <= pool_cnt - CW'(1);
                  state_ff         <= ret_ff;
               end else begin
                  state_ff <= S_SH_WR;
               end
            end

            S_SH_WR: begin
               qpos_ff  <= qnext;
               state_ff <= S_SH_RD;
            end

            // grant queue heads in pool order
            S_GHEAD: begin
               if (pool_ff == POOL_END) begin
                  status_ff <= ST_DONE;
                  state_ff  <= S_STATUS;
               end else if (pool_cnt == '0 || ngrant_ff >= grant_limit) begin
                  pool_ff <= pool_ff + 2'd1;
               end else begin
                  state_ff <= S_GCHECK;
               end
            end

            S_GCHECK: begin
               if (avail_ff[pool_ff] < q_rd.amount) begin
                  pool_ff  <= pool_ff + 2'd1;
                  state_ff <= S_GHEAD;
               end else begin
                  client_ff     <= q_rd.client;
                  job_ff        <= q_rd.job;
                  amount_ff     <= q_rd.amount;
                  res_ff        <= pool_ff;
                  purpose_ff    <= P_GRANT;
                  scan_ff       <= '0;
                  free_found_ff <= 1'b0;
                  state_ff      <= S_FIND_RD;
               end
            end

            S_GEMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= 1'b1;
                  rsp_last_ff  <= 1'b0;
                  rsp_data_ff  <= {6'd0, ngrant_ff + 5'd1, amount_ff, pool_ff, job_ff,
                                   client_ff, ST_GRANTED};
                  ngrant_ff    <= ngrant_ff + 5'd1;
                  qpos_ff      <= '0;
                  ret_ff       <= S_GHEAD;
                  state_ff     <= S_SH_RD;
               end
            end

            S_STATUS: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= 1'b0;
                  rsp_last_ff  <= 1'b1;
                  rsp_data_ff  <= {6'd0, ngrant_ff, 16'd0, 2'd0, 16'd0, 8'd0, status_ff};
                  state_ff     <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // grants in one request never pass the cap
   a_grant_cap: assert property (@(posedge clock) disable iff (reset)
      ngrant_ff <= 5'(GRANT_CAP))
      else $error("grant count above cap");

   // queue lengths stay within depth
   a_queue_len: assert property (@(posedge clock) disable iff (reset)
      qcnt_ff[0] <= CW'(QUEUE_DEPTH) && qcnt_ff[1] <= CW'(QUEUE_DEPTH) &&
      qcnt_ff[2] <= CW'(QUEUE_DEPTH))
      else $error("queue length above depth");

   // a status result always closes the run
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_kind_ff |-> rsp_last_ff)
      else $error("status result not marked last");

   // an accepted request is decoded next
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_DECODE)
      else $error("accepted request not decoded");
endmodule
